// ===== src/nnsb_pkg.sv =====
`default_nettype none

package nnsb_pkg;

    // Field widths
    localparam int CFG_W   = 13;    // dimension / stride registers
    localparam int OFS_W   = 12;    // dst_x / dst_y
    localparam int COL_W   = 12;    // target and source column
    localparam int ROW_W   = 11;    // target row
    localparam int SRC_W   = 12;    // source row
    localparam int CH_W    = 8;     // one color channel
    localparam int ADDR_W  = 25;
    localparam int PIX_W   = 24;
    localparam int IDX_W   = 24;
    localparam int REG_IDX_W = 3;

    // Long division: dividend is column times width, one quotient bit per step
    localparam int DIV_N_W   = COL_W + CFG_W;
    localparam int DIV_STEPS = DIV_N_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int MAX_DIM_DEFAULT = 4096;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DST_STRIDE = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DST_X      = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_DST_Y      = 3'd6;

    typedef struct packed {
        logic accept;   // take input beat, advance target counters
        logic load;     // form the two dividends
        logic step;     // one division step
        logic finish;   // form source index, load output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_last; // current step is the final one
        logic out_free; // output register can take a result this cycle
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== src/nnsb_if.sv =====
`default_nettype none

interface nnsb_in_if;
    logic                      valid;
    logic                      ready;
    logic [nnsb_pkg::CH_W-1:0] src_red;
    logic [nnsb_pkg::CH_W-1:0] src_green;
    logic [nnsb_pkg::CH_W-1:0] src_blue;

    modport source (output valid, output src_red, output src_green, output src_blue,
                    input ready);
    modport sink   (input valid, input src_red, input src_green, input src_blue,
                    output ready);
endinterface

interface nnsb_out_if;
    logic                        valid;
    logic                        ready;
    logic [nnsb_pkg::ADDR_W-1:0] dest_address;
    logic [nnsb_pkg::PIX_W-1:0]  dest_pixel;
    logic [nnsb_pkg::IDX_W-1:0]  next_src_index;
    logic                        frame_last;

    modport source (output valid, output dest_address, output dest_pixel,
                    output next_src_index, output frame_last, input ready);
    modport sink   (input valid, input dest_address, input dest_pixel,
                    input next_src_index, input frame_last, output ready);
endinterface

`default_nettype wire

// ===== src/nnsb_ctrl.sv =====
`default_nettype none

module nnsb_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire nnsb_pkg::dp_stat_t stat,
    output nnsb_pkg::ctrl_cmd_t     cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_IDX  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.load   = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_IDX;
                end
            end
            S_IDX:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    a_accept_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> (state_reg == S_MUL))
        else $error("accepted beat did not start the multiply step");

    a_div_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && !stat.div_last) |=> (state_reg == S_DIV))
        else $error("division left before its last step");

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> stat.out_free)
        else $error("result written over a pending output beat");

    a_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.load, cmd.step, cmd.finish}))
        else $error("more than one datapath command at once");
`endif

endmodule

`default_nettype wire

// ===== src/nnsb_dp.sv =====
`default_nettype none

module nnsb_dp
#(
    parameter int MAX_DIM = nnsb_pkg::MAX_DIM_DEFAULT
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [nnsb_pkg::REG_IDX_W-1:0]  cfg_index,
    input  wire logic [nnsb_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic [nnsb_pkg::CH_W-1:0]       src_red,
    input  wire logic [nnsb_pkg::CH_W-1:0]       src_green,
    input  wire logic [nnsb_pkg::CH_W-1:0]       src_blue,
    input  wire nnsb_pkg::ctrl_cmd_t             cmd,
    output nnsb_pkg::dp_stat_t                   stat,
    nnsb_out_if.source                           pixel_out
);

    localparam int CW = nnsb_pkg::CFG_W;
    localparam int NW = nnsb_pkg::DIV_N_W;
    localparam logic [CW:0] MAX_LIM = (CW+1)'(MAX_DIM);

    function automatic logic [CW-1:0] clamp_dim(input logic [CW-1:0] v,
                                                input logic [CW-1:0] lo);
        logic [CW-1:0] r;
        if (v < lo)
            r = lo;
        else if ({1'b0, v} > MAX_LIM)
            r = MAX_LIM[CW-1:0];
        else
            r = v;
        return r;
    endfunction

    // Configuration
    logic [CW-1:0]                  src_width_reg, src_height_reg;
    logic [CW-1:0]                  dst_width_reg, dst_height_reg, dst_stride_reg;
    logic [nnsb_pkg::OFS_W-1:0]     dst_x_reg, dst_y_reg;

    // Walk state
    logic [nnsb_pkg::COL_W-1:0]     target_column_reg;
    logic [nnsb_pkg::ROW_W-1:0]     target_row_reg;
    logic [nnsb_pkg::COL_W-1:0]     source_column_reg;
    logic [nnsb_pkg::SRC_W-1:0]     source_row_reg;
    logic [CW-1:0]                  column_remainder_reg, row_remainder_reg;

    // Divider dividend / quotient shift registers and step count
    logic [NW-1:0]                  col_num_reg, row_num_reg;
    logic [nnsb_pkg::DIV_CNT_W-1:0] cnt_reg;

    // Per-beat work registers
    logic [nnsb_pkg::ADDR_W-1:0]    addr_work_reg;
    logic [nnsb_pkg::PIX_W-1:0]     pixel_work_reg;
    logic                           last_work_reg;

    // Output register
    logic                           out_valid_reg;
    logic [nnsb_pkg::ADDR_W-1:0]    out_addr_reg;
    logic [nnsb_pkg::PIX_W-1:0]     out_pixel_reg;
    logic [nnsb_pkg::IDX_W-1:0]     out_index_reg;
    logic                           out_last_reg;

    logic [CW-1:0]   sw, sh, tw, th_full;
    logic [CW-2:0]   th;
    logic [CW-1:0]   col_inc;
    logic [CW-2:0]   row_inc;
    logic            row_end, last;
    logic [CW-1:0]   row_base;
    logic [2*CW-1:0] addr_prod, addr_sum;
    logic [NW-1:0]   col_prod;
    logic [NW-2:0]   row_prod;
    logic [CW:0]     col_ext, row_ext;
    logic            col_ge, row_ge;
    logic [CW-1:0]   col_rem_next, row_rem_next;
    logic [NW-1:0]   col_num_next, row_num_next;
    logic [NW-1:0]   idx_prod;
    logic [NW-1:0]   idx_sum;

    assign sw      = clamp_dim(src_width_reg, CW'(1));
    assign sh      = clamp_dim(src_height_reg, CW'(1));
    assign tw      = clamp_dim(dst_width_reg, CW'(1));
    assign th_full = clamp_dim(dst_height_reg, CW'(2));
    assign th      = th_full[CW-1:1];

    // Target advance
    assign col_inc = {1'b0, target_column_reg} + CW'(1);
    assign row_inc = {1'b0, target_row_reg} + (CW-1)'(1);
    assign row_end = (col_inc >= tw);
    assign last    = row_end && (row_inc >= th);

    // Destination address of the current target pixel
    assign row_base  = {1'b0, dst_y_reg} + {2'b00, target_row_reg};
    assign addr_prod = row_base * dst_stride_reg;
    assign addr_sum  = addr_prod + (2*CW)'(dst_x_reg) + (2*CW)'(target_column_reg);

    // Dividends
    assign col_prod = target_column_reg * sw;
    assign row_prod = target_row_reg * sh;

    // Restoring division, one quotient bit per step for each axis
    assign col_ext      = {column_remainder_reg, col_num_reg[NW-1]};
    assign col_ge       = (col_ext >= {1'b0, tw});
    assign col_rem_next = col_ge ? CW'(col_ext - {1'b0, tw}) : col_ext[CW-1:0];
    assign col_num_next = {col_num_reg[NW-2:0], col_ge};

    assign row_ext      = {row_remainder_reg, row_num_reg[NW-1]};
    assign row_ge       = (row_ext >= {2'b00, th});
    assign row_rem_next = row_ge ? CW'(row_ext - {2'b00, th}) : row_ext[CW-1:0];
    assign row_num_next = {row_num_reg[NW-2:0], row_ge};

    // Next source index
    assign idx_prod = source_row_reg * sw;
    assign idx_sum  = idx_prod + NW'(source_column_reg);

    assign stat.div_last = (cnt_reg == nnsb_pkg::DIV_CNT_W'(nnsb_pkg::DIV_STEPS - 1));
    assign stat.out_free = !out_valid_reg || pixel_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg        <= CW'(1);
            src_height_reg       <= CW'(1);
            dst_width_reg        <= CW'(1);
            dst_height_reg       <= CW'(2);
            dst_stride_reg       <= CW'(1);
            dst_x_reg            <= '0;
            dst_y_reg            <= '0;
            target_column_reg    <= '0;
            target_row_reg       <= '0;
            source_column_reg    <= '0;
            source_row_reg       <= '0;
            column_remainder_reg <= '0;
            row_remainder_reg    <= '0;
            cnt_reg              <= '0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    nnsb_pkg::REG_SRC_WIDTH:  src_width_reg  <= cfg_data;
                    nnsb_pkg::REG_SRC_HEIGHT: src_height_reg <= cfg_data;
                    nnsb_pkg::REG_DST_WIDTH:  dst_width_reg  <= cfg_data;
                    nnsb_pkg::REG_DST_HEIGHT: dst_height_reg <= cfg_data;
                    nnsb_pkg::REG_DST_STRIDE: dst_stride_reg <= cfg_data;
                    nnsb_pkg::REG_DST_X:      dst_x_reg      <= cfg_data[nnsb_pkg::OFS_W-1:0];
                    nnsb_pkg::REG_DST_Y:      dst_y_reg      <= cfg_data[nnsb_pkg::OFS_W-1:0];
                    default:                  ;
                endcase
            end

            if (cmd.accept)
            begin
                if (!row_end)
                begin
                    target_column_reg <= col_inc[nnsb_pkg::COL_W-1:0];
                end
                else
                begin
                    target_column_reg <= '0;
                    target_row_reg    <= last ? '0 : row_inc[nnsb_pkg::ROW_W-1:0];
                end
            end

            if (cmd.load)
            begin
                column_remainder_reg <= '0;
                row_remainder_reg    <= '0;
                cnt_reg              <= '0;
            end
            else if (cmd.step)
            begin
                column_remainder_reg <= col_rem_next;
                row_remainder_reg    <= row_rem_next;
                cnt_reg              <= cnt_reg + nnsb_pkg::DIV_CNT_W'(1);
                if (stat.div_last)
                begin
                    source_column_reg <= col_num_next[nnsb_pkg::COL_W-1:0];
                    source_row_reg    <= row_num_next[nnsb_pkg::SRC_W-1:0];
                end
            end

            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (pixel_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            addr_work_reg  <= addr_sum[nnsb_pkg::ADDR_W-1:0];
            pixel_work_reg <= {src_red, src_green, src_blue};
            last_work_reg  <= last;
        end
        if (cmd.load)
        begin
            col_num_reg <= col_prod;
            row_num_reg <= {1'b0, row_prod};
        end
        else if (cmd.step)
        begin
            col_num_reg <= col_num_next;
            row_num_reg <= row_num_next;
        end
        if (cmd.finish)
        begin
            out_addr_reg  <= addr_work_reg;
            out_pixel_reg <= pixel_work_reg;
            out_index_reg <= idx_sum[nnsb_pkg::IDX_W-1:0];
            out_last_reg  <= last_work_reg;
        end
    end

    assign pixel_out.valid          = out_valid_reg;
    assign pixel_out.dest_address   = out_addr_reg;
    assign pixel_out.dest_pixel     = out_pixel_reg;
    assign pixel_out.next_src_index = out_index_reg;
    assign pixel_out.frame_last     = out_last_reg;

`ifndef SYNTH
    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pixel_out.ready) |=> (out_valid_reg && $stable(out_index_reg)))
        else $error("pending result changed before it was taken");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.step) |-> (column_remainder_reg < tw))
        else $error("column remainder not below divisor");

    a_wrap_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && last) |=> (target_column_reg == '0 && target_row_reg == '0))
        else $error("walk did not return to frame start after last pixel");
`endif

endmodule

`default_nettype wire

// ===== src/nearest_neighbor_scale_blit_core.sv =====
// An accepted input beat goes through the dividend, division and index states before its result beat is valid.
// Items are handled one at a time: the next beat is taken only once the previous result is in the output register;
//   each item passes through the 25-step shift-subtract divider (one quotient bit a cycle).
// The next input beat is taken while the previous result still waits in the output register.
// Reset (rst_n low, asynchronous) clears the walk counters and the output valid and loads
//   the registers with 1, 1, 1, 2, 1, 0, 0.
`default_nettype none

module nearest_neighbor_scale_blit_core
#(
    parameter int MAX_DIM = nnsb_pkg::MAX_DIM_DEFAULT
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [nnsb_pkg::REG_IDX_W-1:0] cfg_index,
    input  wire logic [nnsb_pkg::CFG_W-1:0]     cfg_data,
    nnsb_in_if.sink                             pixel_in,
    nnsb_out_if.source                          pixel_out
);

    // Controller <-> datapath
    nnsb_pkg::ctrl_cmd_t cmd;
    nnsb_pkg::dp_stat_t  stat;
    logic                in_ready;

    // Sequencer: idle -> build dividends -> 25 division steps -> index and output.
    // An input beat is taken only in idle; the output register decouples the sink side.
    nnsb_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixel_in.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    assign pixel_in.ready = in_ready;

    // Datapath: config registers, target walk, address multiply, two shared-step
    // dividers (column and row), source index multiply-add, output register.
    nnsb_dp
    #(
        .MAX_DIM (MAX_DIM)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .src_red   (pixel_in.src_red),
        .src_green (pixel_in.src_green),
        .src_blue  (pixel_in.src_blue),
        .cmd       (cmd),
        .stat      (stat),
        .pixel_out (pixel_out)
    );

endmodule

`default_nettype wire
